[hdl/assert_macros.svh]
// Assertion macros used by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Condition holds in every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

`endif

[hdl/flx_pkg.sv]
// Package of the float literal lexer: phases, character codes, register map.
package flx_pkg;

  localparam int TOKEN_CAPACITY = 64;
  localparam int LIMIT_W        = 12;
  localparam int LENGTH_W       = 7;
  localparam int CHAR_W         = 8;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  typedef enum logic [2:0] {
    PH_MANT_SIGN = 3'd0,
    PH_HEX_ZERO  = 3'd1,
    PH_HEX_X     = 3'd2,
    PH_MANT      = 3'd3,
    PH_EXP_SIGN  = 3'd4,
    PH_EXP       = 3'd5
  } phase_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_RADIX_MODE  = 1'b0,
    REG_FIELD_LIMIT = 1'b1
  } reg_idx_t;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LE    = 8'h65;
  localparam logic [CHAR_W-1:0] CH_UE    = 8'h45;
  localparam logic [CHAR_W-1:0] CH_LP    = 8'h70;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h50;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

  function automatic logic is_dec(input logic [CHAR_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_hex_letter(input logic [CHAR_W-1:0] c);
    return ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

endpackage

[hdl/float_literal_lexer_unit.sv]
// Top level of the float literal lexer: one character in, one verdict out.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | to block  | in_valid / in_ready  | char_code, end_of_input
//  out     | from block| out_valid / out_ready| consumed, stored, ended, token_length
//  cfg     | to block  | APB psel/penable     | radix_mode (0x0), field_limit (0x4)
//
// One item per cycle while the result is not stalled; each item passes the input register,
// then the result register. The phase machine is updated when an item moves from the input
// register into the result register, so consecutive items see each other's state.
// Synchronous active-high reset clears the phase, count, point flag, configuration
// registers and both valid flags. A stalled result holds the input register; in_ready
// then drops once that register is also full.
`include "assert_macros.svh"

module float_literal_lexer_unit #(
  parameter int TOKEN_CAPACITY = flx_pkg::TOKEN_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  // item input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [flx_pkg::CHAR_W-1:0]   char_code,
  input  logic                         end_of_input,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         consumed,
  output logic                         stored,
  output logic                         ended,
  output logic [flx_pkg::LENGTH_W-1:0] token_length,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flx_pkg::ADDR_W-1:0]   paddr,
  input  logic [flx_pkg::DATA_W-1:0]   pwdata,
  output logic [flx_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int CNT_W = $clog2(TOKEN_CAPACITY + 1);
  localparam int LW    = flx_pkg::LIMIT_W;
  localparam int LENW  = flx_pkg::LENGTH_W;
  localparam int DW    = flx_pkg::DATA_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(TOKEN_CAPACITY);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic          radix_mode;
  logic [LW-1:0] field_limit;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode  <= 1'b0;
      field_limit <= '0;
    end else if (cfg_write) begin
      case (flx_pkg::reg_idx_t'(paddr[2]))
        flx_pkg::REG_RADIX_MODE:  radix_mode  <= pwdata[0];
        flx_pkg::REG_FIELD_LIMIT: field_limit <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (flx_pkg::reg_idx_t'(paddr[2]))
      flx_pkg::REG_RADIX_MODE:  prdata = DW'(radix_mode);
      flx_pkg::REG_FIELD_LIMIT: prdata = DW'(field_limit);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                       in_full;
  logic [flx_pkg::CHAR_W-1:0] in_char;
  logic                       in_eoi;
  logic                       advance;

  // the held item moves on whenever the result register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char <= char_code;
      in_eoi  <= end_of_input;
    end
  end

  // ---------------------------------------------------------------------------
  // Lexer state
  // ---------------------------------------------------------------------------
  flx_pkg::phase_t  phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic             point_seen, point_seen_next;

  logic hex;
  logic is_sgn;
  logic is_exp_letter;
  logic limit_on;
  logic limit_hit;         // count already at the limit before this item
  flx_pkg::phase_t eff_phase;   // phase after sign phases have been skipped
  flx_pkg::phase_t adv_phase;   // phase reached when the item is taken
  logic take, keep, stop, point_set;
  logic             grow;
  logic [CNT_W-1:0] count_new;
  logic             end_all;

  assign hex           = radix_mode;
  assign is_sgn        = !in_eoi && flx_pkg::is_sign(in_char);
  assign is_exp_letter = hex ? ((in_char == flx_pkg::CH_LP) || (in_char == flx_pkg::CH_UP))
                             : ((in_char == flx_pkg::CH_LE) || (in_char == flx_pkg::CH_UE));
  assign limit_on      = (field_limit != '0);
  assign limit_hit     = limit_on && (LW'(count) >= field_limit);

  // Next-state side: a sign phase without a sign falls through to its successor
  always_comb begin
    eff_phase = phase;
    adv_phase = phase;
    case (phase)
      flx_pkg::PH_MANT_SIGN: if (!is_sgn) eff_phase = hex ? flx_pkg::PH_HEX_ZERO
                                                           : flx_pkg::PH_MANT;
      flx_pkg::PH_EXP_SIGN:  if (!is_sgn) eff_phase = flx_pkg::PH_EXP;
      default: ;
    endcase
    case (eff_phase)
      flx_pkg::PH_MANT_SIGN: adv_phase = hex ? flx_pkg::PH_HEX_ZERO : flx_pkg::PH_MANT;
      flx_pkg::PH_HEX_ZERO:  adv_phase = flx_pkg::PH_HEX_X;
      flx_pkg::PH_HEX_X:     adv_phase = flx_pkg::PH_MANT;
      flx_pkg::PH_MANT:      adv_phase = is_exp_letter ? flx_pkg::PH_EXP_SIGN
                                                       : flx_pkg::PH_MANT;
      flx_pkg::PH_EXP_SIGN:  adv_phase = flx_pkg::PH_EXP;
      flx_pkg::PH_EXP:       adv_phase = flx_pkg::PH_EXP;
      default:               adv_phase = flx_pkg::PH_MANT_SIGN;
    endcase
  end

  // Output side: what the character does to the token
  always_comb begin
    take      = 1'b0;
    keep      = 1'b0;
    stop      = 1'b0;
    point_set = 1'b0;
    case (eff_phase)
      flx_pkg::PH_MANT_SIGN, flx_pkg::PH_EXP_SIGN: begin
        // only reached with a sign in hand
        take = 1'b1;
        keep = 1'b1;
      end
      flx_pkg::PH_HEX_ZERO: begin
        if (!in_eoi && (in_char == flx_pkg::CH_0)) take = 1'b1;
        else                                       stop = 1'b1;
      end
      flx_pkg::PH_HEX_X: begin
        if (!in_eoi && ((in_char == flx_pkg::CH_LX) || (in_char == flx_pkg::CH_UX)))
          take = 1'b1;
        else
          stop = 1'b1;
      end
      flx_pkg::PH_MANT: begin
        if (in_eoi) begin
          stop = 1'b1;
        end else if (flx_pkg::is_dec(in_char) || is_exp_letter ||
                     (hex && flx_pkg::is_hex_letter(in_char))) begin
          take = 1'b1;
          keep = 1'b1;
        end else if ((in_char == flx_pkg::CH_POINT) && !point_seen) begin
          take      = 1'b1;
          keep      = 1'b1;
          point_set = 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
      flx_pkg::PH_EXP: begin
        if (!in_eoi && flx_pkg::is_dec(in_char)) begin
          take = 1'b1;
          keep = 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
      default: stop = 1'b1;
    endcase
    // a limit already reached overrides everything: nothing is taken
    if (limit_hit) begin
      take      = 1'b0;
      keep      = 1'b0;
      stop      = 1'b1;
      point_set = 1'b0;
    end
  end

  // Past capacity, characters are still consumed but no longer stored
  assign grow      = take && keep && (count < CAP);
  assign count_new = count + CNT_W'(grow);
  assign end_all   = stop || (take && limit_on && (LW'(count_new) >= field_limit));

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    point_seen_next = point_seen;
    if (advance) begin
      if (end_all) begin
        phase_next      = flx_pkg::PH_MANT_SIGN;
        count_next      = '0;
        point_seen_next = 1'b0;
      end else begin
        phase_next      = take ? adv_phase : eff_phase;
        count_next      = count_new;
        point_seen_next = point_seen || point_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= flx_pkg::PH_MANT_SIGN;
      count      <= '0;
      point_seen <= 1'b0;
    end else begin
      phase      <= phase_next;
      count      <= count_next;
      point_seen <= point_seen_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      consumed     <= take;
      stored       <= grow;
      ended        <= end_all;
      token_length <= LENW'(count_new);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_stored_needs_consumed, clk, rst, out_valid && stored, consumed)
  `ASSERT_NEXT(a_end_clears_state, clk, rst, advance && end_all,
               phase == flx_pkg::PH_MANT_SIGN && count == '0 && !point_seen)
  `ASSERT_ALWAYS(a_count_within_capacity, clk, rst, count <= CAP)
  `ASSERT_IMPLIES(a_prefix_count_small, clk, rst,
                  phase == flx_pkg::PH_HEX_ZERO || phase == flx_pkg::PH_HEX_X,
                  count <= CNT_W'(1))

endmodule

[tb/tb.sv]
// Testbench of the float literal lexer: character streams checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run, far beyond the slowest legal schedule.
  localparam int RUN_LIMIT = 200000;
  // Cycles allowed after the last result before touching the registers or ending.
  localparam int SETTLE = 4;

  typedef logic [flx_pkg::CHAR_W-1:0] char_t;

  typedef struct packed {
    logic                         consumed;
    logic                         stored;
    logic                         ended;
    logic [flx_pkg::LENGTH_W-1:0] token_length;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Block ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  char_t                        char_code    = '0;
  logic                         end_of_input = 1'b0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic                         consumed;
  logic                         stored;
  logic                         ended;
  logic [flx_pkg::LENGTH_W-1:0] token_length;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [flx_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [flx_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [flx_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  float_literal_lexer_unit u_top (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: lexer phase, stored count, point flag and register copies
  // ---------------------------------------------------------------------------
  flx_pkg::phase_t             lx_phase  = flx_pkg::PH_MANT_SIGN;
  int unsigned                 lx_count  = 0;
  logic                        lx_point  = 1'b0;
  logic                        cfg_hex   = 1'b0;
  logic [flx_pkg::LIMIT_W-1:0] cfg_limit = '0;

  verdict_t            verdict_q[$];   // verdicts of accepted items, oldest first
  int                  err_count   = 0;
  int                  items_sent  = 0;
  int                  cycle_count = 0;
  int                  src_gap_pct = 7;   // chance per cycle that the sender idles
  int                  snk_gap_pct = 57;  // chance per cycle that the receiver stalls
  int                  stall_left  = 0;   // long receiver hold-off, in cycles

  function automatic logic sign_char(input char_t c);
    return (c == flx_pkg::CH_MINUS) || (c == flx_pkg::CH_PLUS);
  endfunction

  function automatic logic dec_digit(input char_t c);
    return (c >= flx_pkg::CH_0) && (c <= flx_pkg::CH_9);
  endfunction

  function automatic logic hex_alpha(input char_t c);
    return ((c >= flx_pkg::CH_LA) && (c <= flx_pkg::CH_LF)) ||
           ((c >= flx_pkg::CH_UA) && (c <= flx_pkg::CH_UF));
  endfunction

  // Verdict for one character; advances the predictor's token state.
  function automatic verdict_t lex_char(input char_t c, input logic eoi);
    verdict_t v;
    logic     take;
    logic     keep;
    logic     done;
    logic     fin;
    logic     exp_letter;
    int       hops;
    v    = '0;
    take = 1'b0;
    keep = 1'b0;
    done = 1'b0;
    fin  = 1'b0;
    exp_letter = cfg_hex ? (c == flx_pkg::CH_LP || c == flx_pkg::CH_UP)
                         : (c == flx_pkg::CH_LE || c == flx_pkg::CH_UE);
    // limit already reached (register lowered mid-token): end, nothing taken
    if (cfg_limit != 0 && lx_count >= cfg_limit) begin
      fin  = 1'b1;
      done = 1'b1;
    end
    // sign phases fall through to the next phase in the same step
    for (hops = 0; hops < 4 && !done; hops++) begin
      case (lx_phase)
        flx_pkg::PH_MANT_SIGN: begin
          if (!eoi && sign_char(c)) begin
            take = 1'b1;
            keep = 1'b1;
            done = 1'b1;
          end
          lx_phase = cfg_hex ? flx_pkg::PH_HEX_ZERO : flx_pkg::PH_MANT;
        end
        flx_pkg::PH_HEX_ZERO: begin
          if (!eoi && c == flx_pkg::CH_0) begin
            take     = 1'b1;
            lx_phase = flx_pkg::PH_HEX_X;
          end else
            fin = 1'b1;
          done = 1'b1;
        end
        flx_pkg::PH_HEX_X: begin
          if (!eoi && (c == flx_pkg::CH_LX || c == flx_pkg::CH_UX)) begin
            take     = 1'b1;
            lx_phase = flx_pkg::PH_MANT;
          end else
            fin = 1'b1;
          done = 1'b1;
        end
        flx_pkg::PH_MANT: begin
          done = 1'b1;
          if (eoi)
            fin = 1'b1;
          else if (dec_digit(c)) begin
            take = 1'b1;
            keep = 1'b1;
          end else if (exp_letter) begin
            take     = 1'b1;
            keep     = 1'b1;
            lx_phase = flx_pkg::PH_EXP_SIGN;
          end else if (cfg_hex && hex_alpha(c)) begin
            take = 1'b1;
            keep = 1'b1;
          end else if (c == flx_pkg::CH_POINT && !lx_point) begin
            take     = 1'b1;
            keep     = 1'b1;
            lx_point = 1'b1;
          end else
            fin = 1'b1;
        end
        flx_pkg::PH_EXP_SIGN: begin
          if (!eoi && sign_char(c)) begin
            take = 1'b1;
            keep = 1'b1;
            done = 1'b1;
          end
          lx_phase = flx_pkg::PH_EXP;
        end
        flx_pkg::PH_EXP: begin
          done = 1'b1;
          if (!eoi && dec_digit(c)) begin
            take = 1'b1;
            keep = 1'b1;
          end else
            fin = 1'b1;
        end
        default: begin
          done = 1'b1;
          fin  = 1'b1;
        end
      endcase
    end
    if (!done)
      fin = 1'b1;
    if (take) begin
      v.consumed = 1'b1;
      // past capacity the character is still taken but not kept
      if (keep && lx_count < flx_pkg::TOKEN_CAPACITY) begin
        lx_count++;
        v.stored = 1'b1;
      end
      if (cfg_limit != 0 && lx_count >= cfg_limit)
        fin = 1'b1;
    end
    v.ended        = fin;
    v.token_length = flx_pkg::LENGTH_W'(lx_count);
    if (fin) begin
      lx_phase = flx_pkg::PH_MANT_SIGN;
      lx_count = 0;
      lx_point = 1'b0;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off while stall_left runs down
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else
      out_ready = ($urandom_range(99) >= snk_gap_pct);
  end

  // Result checker: every accepted result against the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        err_count++;
        $error("result item arrived with no item pending");
      end else begin
        want = verdict_q.pop_front();
        if (consumed !== want.consumed) begin
          err_count++;
          $error("consumed: expected %0d, got %0d", want.consumed, consumed);
        end
        if (stored !== want.stored) begin
          err_count++;
          $error("stored: expected %0d, got %0d", want.stored, stored);
        end
        if (ended !== want.ended) begin
          err_count++;
          $error("ended: expected %0d, got %0d", want.ended, ended);
        end
        if (token_length !== want.token_length) begin
          err_count++;
          $error("token_length: expected %0d, got %0d", want.token_length, token_length);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access
  // ---------------------------------------------------------------------------

  // Offer one item; returns at the rising edge that accepted it.
  task automatic send_char(input char_t c, input logic eoi);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    char_code    = c;
    end_of_input = eoi;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    verdict_q.push_back(lex_char(c, eoi));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(char_t'(s[i]), 1'b0);
  endtask

  // Stop offering and wait until every pending result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write once idle, then read it back.
  task automatic cfg_write(input flx_pkg::reg_idx_t idx, input int unsigned value);
    logic [flx_pkg::DATA_W-1:0] want;
    wait_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (idx == flx_pkg::REG_RADIX_MODE)
      cfg_hex = value[0];
    else
      cfg_limit = value[flx_pkg::LIMIT_W-1:0];
    want = (idx == flx_pkg::REG_RADIX_MODE) ? flx_pkg::DATA_W'(cfg_hex)
                                            : flx_pkg::DATA_W'(cfg_limit);
    // read-back as a second transfer
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    if (prdata !== want) begin
      err_count++;
      $error("prdata: expected %0h, got %0h", want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random token source
  // ---------------------------------------------------------------------------
  function automatic char_t any_sign();
    return $urandom_range(1) ? flx_pkg::CH_MINUS : flx_pkg::CH_PLUS;
  endfunction

  function automatic char_t mant_digit(input logic hex);
    int unsigned pick;
    pick = $urandom_range(hex ? 21 : 9);
    if (pick < 10)
      return flx_pkg::CH_0 + char_t'(pick);
    else if (pick < 16)
      return flx_pkg::CH_LA + char_t'(pick - 10);
    else
      return flx_pkg::CH_UA + char_t'(pick - 16);
  endfunction

  // Mostly well-formed literals in the current radix, some corrupted, some noise.
  task automatic send_random_token();
    char_t tok[$];
    int    n;
    int    point_at;
    logic  hex;
    hex = cfg_hex;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) send_char(char_t'($urandom_range(255)), $urandom_range(99) < 10);
    end else begin
      if ($urandom_range(1))
        tok.push_back(any_sign());
      if (hex) begin
        tok.push_back(flx_pkg::CH_0);
        tok.push_back($urandom_range(1) ? flx_pkg::CH_LX : flx_pkg::CH_UX);
      end
      // now and then a mantissa long enough to run past the capacity
      n        = ($urandom_range(99) < 4) ? $urandom_range(60, 75) : $urandom_range(0, 8);
      point_at = $urandom_range(0, n + 3);
      for (int i = 0; i <= n; i++) begin
        if (i == point_at)
          tok.push_back(flx_pkg::CH_POINT);
        if (i < n)
          tok.push_back(mant_digit(hex));
      end
      if ($urandom_range(2) != 0) begin
        if (hex)
          tok.push_back($urandom_range(1) ? flx_pkg::CH_LP : flx_pkg::CH_UP);
        else
          tok.push_back($urandom_range(1) ? flx_pkg::CH_LE : flx_pkg::CH_UE);
        if ($urandom_range(1))
          tok.push_back(any_sign());
        repeat ($urandom_range(0, 4)) tok.push_back(mant_digit(1'b0));
      end
      // broken sequence: one character replaced by any byte
      if (tok.size() != 0 && $urandom_range(99) < 10)
        tok[$urandom_range(tok.size() - 1)] = char_t'($urandom_range(255));
      foreach (tok[i])
        send_char(tok[i], 1'b0);
      // terminator: end of input or any byte
      if ($urandom_range(3) == 0)
        send_char(char_t'($urandom_range(255)), 1'b1);
      else
        send_char(char_t'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic run_tokens(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target)
      send_random_token();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Decimal forms: sign, point, exponent, end on a stray character, second
  // point, end of input in the start phase.
  task automatic test_decimal();
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 0);
    send_text("-1.5e+3 7..");
    send_char(8'hFF, 1'b1);
  endtask

  // Hex forms: prefix consumed but not kept, p exponent, then a missing 0 and
  // a missing x.
  task automatic test_hex();
    cfg_write(flx_pkg::REG_RADIX_MODE, 1);
    send_text("+0xAfp3");
    send_char(8'h00, 1'b1);
    send_text("50Z");
  endtask

  // Field limit: token ends on the limiting character; lowering the limit
  // under the count ends the token on the next item without taking it.
  task automatic test_field_limit();
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 2);
    send_text("12");
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 4095);
    send_text("34");
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 1);
    send_text("5");
  endtask

  // Radix switched in the middle of a token: hex prefix phases under decimal.
  task automatic test_mode_switch();
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 0);
    cfg_write(flx_pkg::REG_RADIX_MODE, 1);
    send_text("-");
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    send_text("0x5e1");
    send_char(8'h7F, 1'b1);
  endtask

  // Random streams over several register settings and idling patterns.
  task automatic test_random();
    src_gap_pct = 7;
    snk_gap_pct = 57;
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 0);
    run_tokens(500);

    src_gap_pct = 57;
    snk_gap_pct = 7;
    cfg_write(flx_pkg::REG_RADIX_MODE, 1);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 4095);
    run_tokens(500);

    src_gap_pct = 0;
    snk_gap_pct = 0;
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 0);
    run_tokens(150);
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 1);
    run_tokens(50);
    cfg_write(flx_pkg::REG_RADIX_MODE, 1);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, $urandom_range(2, 12));
    run_tokens(100);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so both stages fill and in_ready drops.
  task automatic test_backpressure();
    cfg_write(flx_pkg::REG_RADIX_MODE, 0);
    cfg_write(flx_pkg::REG_FIELD_LIMIT, 0);
    stall_left = 300;
    run_tokens(80);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_decimal();
    test_hex();
    test_field_limit();
    test_mode_switch();
    test_random();
    test_backpressure();

    wait_idle();
    if (err_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
